// ===== src/tlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types, opcodes and helpers for the fully associative TLB.
// ----------------------------------------------------------------------------
package tlb_pkg;

  // default number of entries
  localparam int TLB_DEPTH_DEFAULT = 16;

  // opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  // access kinds and permissions
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] PERM_BOTH  = 2'd3;

  // input beat
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] virtual_page;
    logic [1:0] access_kind;
    logic [7:0] entry_frame;
  } tlb_in_t;

  // result beat
  typedef struct packed {
    logic       hit;
    logic [7:0] frame_out;
    logic       insert_dropped;
  } tlb_out_t;

  // one stored entry (valid bit kept apart)
  typedef struct packed {
    logic [7:0] page;
    logic [7:0] frame;
    logic [1:0] perm;
  } tlb_entry_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } tlb_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
    logic respond;
  } tlb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic last_addr;
    logic out_free;
  } tlb_sts_t;

  // does a stored permission allow the requested access
  function automatic logic permits(input logic [1:0] perm, input logic [1:0] kind);
    logic ok;
    ok = 1'b0;
    if (kind == KIND_READ) begin
      ok = (perm == KIND_READ) || (perm == PERM_BOTH);
    end else if (kind == KIND_WRITE) begin
      ok = (perm == PERM_BOTH);
    end
    return ok;
  endfunction

endpackage

// ===== src/tlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlb_ctrl
// Sequencer: accepts an item, steps the entry scan, commits and responds.
// ----------------------------------------------------------------------------
module tlb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlb_pkg::tlb_sts_t sts,
  output tlb_pkg::tlb_cmd_t cmd
);

  tlb_pkg::tlb_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tlb_pkg::ST_SCAN;
      end
      tlb_pkg::ST_SCAN: begin
        if (sts.is_flush) state_nxt = tlb_pkg::ST_COMMIT;
        else if (sts.last_addr) state_nxt = tlb_pkg::ST_DRAIN;
      end
      tlb_pkg::ST_DRAIN:  state_nxt = tlb_pkg::ST_COMMIT;
      tlb_pkg::ST_COMMIT: state_nxt = tlb_pkg::ST_RESP;
      tlb_pkg::ST_RESP: begin
        if (sts.out_free) state_nxt = tlb_pkg::ST_IDLE;
      end
      default: state_nxt = tlb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tlb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tlb_pkg::ST_SCAN:   cmd.issue   = !sts.is_flush;
      tlb_pkg::ST_DRAIN:  cmd         = '0;
      tlb_pkg::ST_COMMIT: cmd.commit  = 1'b1;
      tlb_pkg::ST_RESP:   cmd.respond = sts.out_free;
      default:            cmd         = '0;
    endcase
  end

endmodule

// ===== src/tlb_dpath.sv =====
// ----------------------------------------------------------------------------
// tlb_dpath
// Entry store, valid bits, scan pointer, match tracking and result register.
// ----------------------------------------------------------------------------
module tlb_dpath #(
  parameter int TLB_DEPTH = tlb_pkg::TLB_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlb_pkg::tlb_in_t  in_data,
  input  tlb_pkg::tlb_cmd_t cmd,
  output tlb_pkg::tlb_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output tlb_pkg::tlb_out_t out_data
);

  localparam int IDXW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

  // entry store and valid bits
  tlb_pkg::tlb_entry_t mem [TLB_DEPTH];
  tlb_pkg::tlb_entry_t rd_data_r;
  logic [TLB_DEPTH-1:0] valid_r;

  // item and scan state
  tlb_pkg::tlb_in_t item_r;
  logic [IDXW-1:0]  addr_r;
  logic [IDXW-1:0]  chk_idx_r;
  logic             chk_vld_r;
  logic             found_r;
  logic [IDXW-1:0]  slot_r;
  logic             free_r;
  logic [IDXW-1:0]  free_slot_r;
  logic [7:0]       frame_r;

  // result register
  logic             out_valid_r;
  tlb_pkg::tlb_out_t out_data_r;

  logic             ent_vld;
  logic             page_hit;
  logic             is_lookup, is_insert, is_inval, is_flush;
  logic             ins_ok;
  logic [IDXW-1:0]  wr_idx;
  tlb_pkg::tlb_entry_t wr_entry;

  // decode of the held item and the entry under check
  always_comb begin
    is_lookup = (item_r.opcode == tlb_pkg::OP_LOOKUP);
    is_insert = (item_r.opcode == tlb_pkg::OP_INSERT);
    is_inval  = (item_r.opcode == tlb_pkg::OP_INVAL);
    is_flush  = (item_r.opcode == tlb_pkg::OP_FLUSH);
    ent_vld   = valid_r[chk_idx_r];
    page_hit  = chk_vld_r && ent_vld && (rd_data_r.page == item_r.virtual_page);
    ins_ok    = found_r || free_r;
    wr_idx    = found_r ? slot_r : free_slot_r;
    wr_entry.page  = item_r.virtual_page;
    wr_entry.frame = item_r.entry_frame;
    wr_entry.perm  = item_r.access_kind;
  end

  // status to controller
  always_comb begin
    sts.is_flush  = is_flush;
    sts.last_addr = (addr_r == IDXW'(TLB_DEPTH - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // memory write on insert commit, registered read during scan
  always_ff @(posedge clk) begin
    if (cmd.commit && is_insert && ins_ok) begin
      mem[wr_idx] <= wr_entry;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // scan pointer and check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
      addr_r    <= '0;
    end else begin
      chk_vld_r <= cmd.issue;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.issue) begin
        addr_r <= addr_r + 1'b1;
      end
    end
    chk_idx_r <= addr_r;
  end

  // item capture and match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (chk_vld_r) begin
      if (is_lookup && page_hit && !found_r &&
          tlb_pkg::permits(rd_data_r.perm, item_r.access_kind)) begin
        found_r <= 1'b1;
      end
      if (is_insert && page_hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (is_insert && !ent_vld && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  // payload side of the tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      frame_r <= '0;
    end else if (chk_vld_r && !found_r) begin
      if (is_lookup && page_hit &&
          tlb_pkg::permits(rd_data_r.perm, item_r.access_kind)) begin
        frame_r <= rd_data_r.frame;
      end
      if (is_insert && page_hit) begin
        slot_r <= chk_idx_r;
      end
    end
    if (chk_vld_r && is_insert && !ent_vld && !free_r) begin
      free_slot_r <= chk_idx_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && is_flush) begin
      valid_r <= '0;
    end else if (cmd.commit && is_insert && ins_ok) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (is_inval && page_hit) begin
      valid_r[chk_idx_r] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.respond) begin
      out_data_r.hit            <= is_lookup && found_r;
      out_data_r.frame_out      <= (is_lookup && found_r) ? frame_r : 8'd0;
      out_data_r.insert_dropped <= is_insert && !ins_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/tlb_lookup_insert_invalidate.sv =====
// ----------------------------------------------------------------------------
// tlb_lookup_insert_invalidate
// Fully associative TLB with lookup, insert/update, invalidate and flush.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carries one request beat (opcode, page, kind,
//   frame); out_valid/out_ready/out_data returns exactly one result beat per
//   request (hit, frame_out, insert_dropped).
//   Lookup, insert and invalidate walk the entry store one entry per cycle
//   through its single registered read port, and a new request is taken
//   only once the result of the last one is registered. Flush skips the walk.
//   The result sits in an output register; when the receiver stalls the
//   block holds the next finished result until that register frees up and
//   takes no new request meanwhile.
//   Reset (rst_n low, synchronous) clears all valid bits and the control
//   state; the block is ready for a request on the first cycle after reset.
// ----------------------------------------------------------------------------
module tlb_lookup_insert_invalidate #(
  parameter int TLB_DEPTH = tlb_pkg::TLB_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlb_pkg::tlb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tlb_pkg::tlb_out_t out_data
);

  tlb_pkg::tlb_cmd_t cmd;
  tlb_pkg::tlb_sts_t sts;

  // sequencer
  tlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry store and scan datapath
  tlb_dpath #(
    .TLB_DEPTH (TLB_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // in_ready drops after a request beat is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("tlb: ready right after request beat");

  // only one command at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.commit, cmd.respond}))
    else $error("tlb: overlapping commands");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> sts.out_free)
    else $error("tlb: result overwrites pending beat");

  // a loaded result shows up as a valid beat
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> out_valid)
    else $error("tlb: result not presented");

endmodule
